>>> rtl/core/mps_pkg.sv
// Package with the item types, codes and constants of the MAVLink packet segmenter.
`default_nettype none

package mps_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       segment_last;
  } result_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_JUNK = 2'd1,
    KIND_V1   = 2'd2,
    KIND_V2   = 2'd3
  } kind_t;

  localparam logic       CmdData  = 1'b0;
  localparam logic       CmdFlush = 1'b1;

  localparam logic [7:0] StxV1 = 8'hFE;
  localparam logic [7:0] StxV2 = 8'hFD;

  localparam int unsigned PosWidth   = 9;
  localparam int unsigned CountWidth = PosWidth + 1;

  localparam logic [CountWidth-1:0] JunkLimit      = CountWidth'(256);
  localparam logic [PosWidth-1:0]   V1Overhead     = PosWidth'(8);
  localparam logic [PosWidth-1:0]   V2Overhead     = PosWidth'(12);
  localparam logic [PosWidth-1:0]   SignatureBytes = PosWidth'(13);

  localparam int unsigned CfgAddrWidth = 3;
  localparam logic [0:0]  RegPacketiseEnable = 1'b0;

  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = 2;
  localparam int unsigned FifoCountW  = 3;

endpackage

`default_nettype wire

>>> rtl/core/mavlink_packet_segmenter_unit.sv
// Top level of the MAVLink packet segmenter: framing logic, output queue and register port.
`default_nettype none

// Bytes pass through unchanged and in order; segment_last marks the end of each
// datagram-sized segment. One item is taken per cycle while the input is not stalled:
// its framing decision is made combinationally against the segment registers and its
// results, none to two, are written into a four-entry output queue. The queue stalls
// the input while fewer than two entries are free, so a sustained rate of one item per
// cycle holds as long as the result side takes one result per cycle; a start byte that
// closes a junk run, or a junk byte that reaches the limit behind a held byte, yields
// two results. The packetise_enable register sits at byte address 0; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module mavlink_packet_segmenter_unit
  import mps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire item_t                   item,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output result_t                      result,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                packetise_enable;
  logic                hold_valid;
  logic [7:0]          hold_byte;
  kind_t               segment_kind;
  logic [PosWidth-1:0] segment_position;
  logic [PosWidth-1:0] segment_target;

  logic                hold_valid_next;
  logic [7:0]          hold_byte_next;
  kind_t               segment_kind_next;
  logic [PosWidth-1:0] segment_position_next;
  logic [PosWidth-1:0] segment_target_next;

  result_t             fifo [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCountW-1:0] fifo_count;

  logic    r0_valid;
  logic    r1_valid;
  result_t r0;
  result_t r1;

  logic                  item_fire;
  logic                  result_fire;
  logic                  cfg_write;
  logic                  is_stx;
  logic                  in_junk;
  logic [CountWidth-1:0] junk_count;
  logic                  junk_done;
  logic [PosWidth-1:0]   target_len;
  logic [PosWidth-1:0]   target_sig;
  logic                  packet_done;
  logic [FifoCountW-1:0] push_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[CfgAddrWidth-1] == RegPacketiseEnable) ?
                     {31'd0, packetise_enable} : 32'd0;

  assign item_stall   = (fifo_count > FifoCountW'(FifoDepth - 2));
  assign item_fire    = item_valid && !item_stall;
  assign result_valid = (fifo_count != '0);
  assign result       = fifo[rd_ptr];
  assign result_fire  = result_valid && !result_stall;

  assign is_stx  = (item.data_byte == StxV1) || (item.data_byte == StxV2);
  assign in_junk = (segment_kind == KIND_JUNK) && hold_valid;

  assign junk_count = in_junk ? ({1'b0, segment_position} + CountWidth'(1)) : CountWidth'(1);
  assign junk_done  = (junk_count >= JunkLimit);

  assign target_len = (segment_position == PosWidth'(1)) ?
                      ({1'b0, item.data_byte} +
                       ((segment_kind == KIND_V1) ? V1Overhead : V2Overhead)) :
                      segment_target;
  assign target_sig = ((segment_position == PosWidth'(2)) && (segment_kind == KIND_V2) &&
                       item.data_byte[0]) ? (target_len + SignatureBytes) : target_len;
  assign packet_done = (target_sig != '0) &&
                       (({1'b0, segment_position} + CountWidth'(1)) >= {1'b0, target_sig});

  always_comb begin
    hold_valid_next       = hold_valid;
    hold_byte_next        = hold_byte;
    segment_kind_next     = segment_kind;
    segment_position_next = segment_position;
    segment_target_next   = segment_target;
    r0_valid              = 1'b0;
    r1_valid              = 1'b0;
    r0                    = '{out_byte: hold_byte, segment_last: 1'b0};
    r1                    = '{out_byte: item.data_byte, segment_last: 1'b0};
    priority if (item.command == CmdFlush) begin
      if (hold_valid) begin
        r0_valid              = 1'b1;
        r0.segment_last       = 1'b1;
        hold_valid_next       = 1'b0;
        segment_kind_next     = KIND_NONE;
        segment_position_next = '0;
      end
    end else if ((segment_kind == KIND_V1) || (segment_kind == KIND_V2)) begin
      r0_valid            = 1'b1;
      r0.out_byte         = item.data_byte;
      segment_target_next = target_sig;
      if (packet_done) begin
        r0.segment_last       = 1'b1;
        segment_kind_next     = KIND_NONE;
        segment_position_next = '0;
        segment_target_next   = '0;
      end else begin
        segment_position_next = segment_position + PosWidth'(1);
      end
    end else if (!packetise_enable) begin
      r0_valid              = hold_valid;
      hold_valid_next       = 1'b1;
      hold_byte_next        = item.data_byte;
      segment_kind_next     = KIND_JUNK;
      segment_position_next = '0;
    end else if (is_stx) begin
      if (in_junk) begin
        r0_valid        = 1'b1;
        r0.segment_last = 1'b1;
        r1_valid        = 1'b1;
      end else begin
        r0_valid    = 1'b1;
        r0.out_byte = item.data_byte;
      end
      hold_valid_next       = 1'b0;
      segment_kind_next     = (item.data_byte == StxV1) ? KIND_V1 : KIND_V2;
      segment_position_next = PosWidth'(1);
      segment_target_next   = '0;
    end else begin
      if (in_junk) begin
        r0_valid = 1'b1;
        r1_valid = junk_done;
        r1.segment_last = 1'b1;
      end else begin
        r0_valid        = junk_done;
        r0.out_byte     = item.data_byte;
        r0.segment_last = 1'b1;
      end
      if (junk_done) begin
        hold_valid_next       = 1'b0;
        segment_kind_next     = KIND_NONE;
        segment_position_next = '0;
      end else begin
        hold_valid_next       = 1'b1;
        hold_byte_next        = item.data_byte;
        segment_kind_next     = KIND_JUNK;
        segment_position_next = junk_count[PosWidth-1:0];
      end
    end
  end

  assign push_count = item_fire ? (FifoCountW'(r0_valid) + FifoCountW'(r1_valid)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      packetise_enable <= 1'b0;
      hold_valid       <= 1'b0;
      hold_byte        <= '0;
      segment_kind     <= KIND_NONE;
      segment_position <= '0;
      segment_target   <= '0;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      fifo_count       <= '0;
    end else begin
      if (cfg_write && (paddr[CfgAddrWidth-1] == RegPacketiseEnable)) begin
        packetise_enable <= pwdata[0];
      end
      if (item_fire) begin
        hold_valid       <= hold_valid_next;
        hold_byte        <= hold_byte_next;
        segment_kind     <= segment_kind_next;
        segment_position <= segment_position_next;
        segment_target   <= segment_target_next;
      end
      wr_ptr     <= wr_ptr + push_count[FifoPtrW-1:0];
      rd_ptr     <= rd_ptr + FifoPtrW'(result_fire);
      fifo_count <= fifo_count + push_count - FifoCountW'(result_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && r0_valid) begin
      fifo[wr_ptr] <= r0;
    end
    if (item_fire && r1_valid) begin
      fifo[wr_ptr + FifoPtrW'(1)] <= r1;
    end
  end

  // The queue never holds more entries than it has.
  assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FifoCountW'(FifoDepth))
    else $error("output queue overflow");

  // A byte is held exactly while a junk or raw run is open.
  assert property (@(posedge clk) disable iff (rst)
    hold_valid == (segment_kind == KIND_JUNK))
    else $error("hold register out of step with segment kind");

  // An open packet always has a position past its start byte.
  assert property (@(posedge clk) disable iff (rst)
    ((segment_kind == KIND_V1) || (segment_kind == KIND_V2)) |-> (segment_position != '0))
    else $error("packet segment open at position zero");

  // A second result in one item is only pushed behind a first one.
  assert property (@(posedge clk) disable iff (rst)
    (item_fire && r1_valid) |-> r0_valid)
    else $error("second result without a first");

endmodule

`default_nettype wire

>>> tb/sv/tb_mavlink_packet_segmenter_unit.sv
// Self-checking testbench for the MAVLink packet segmenter with its own framing predictor.
`default_nettype none

module tb_mavlink_packet_segmenter_unit;
  import mps_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int PhaseItems = 300;

  class segment_scoreboard;
    logic       packetise;
    logic       hold_valid;
    logic [7:0] hold_byte;
    kind_t      kind;
    logic [8:0] position;
    logic [8:0] target;
    result_t    due_bytes[$];
    int         failures;

    function new();
      packetise  = 1'b0;
      hold_valid = 1'b0;
      hold_byte  = '0;
      kind       = KIND_NONE;
      position   = '0;
      target     = '0;
      failures   = 0;
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    function void emit(logic [7:0] b, logic last);
      result_t r;
      r.out_byte     = b;
      r.segment_last = last;
      due_bytes.push_back(r);
    endfunction

    function void close_junk();
      hold_valid = 1'b0;
      hold_byte  = '0;
      kind       = KIND_NONE;
      position   = '0;
    endfunction

    function void open_packet(logic [7:0] b);
      kind     = (b == StxV1) ? KIND_V1 : KIND_V2;
      position = 9'd1;
      target   = '0;
      emit(b, 1'b0);
    endfunction

    function void junk_byte(logic [7:0] b, logic [9:0] count);
      if (count >= JunkLimit) begin
        emit(b, 1'b1);
        close_junk();
      end else begin
        hold_valid = 1'b1;
        hold_byte  = b;
        kind       = KIND_JUNK;
        position   = count[8:0];
      end
    endfunction

    // Works out the bytes that one accepted item releases and updates the framing state.
    function void note_item(item_t it);
      logic [7:0] b;
      logic       stx;
      logic [8:0] pos;
      b   = it.data_byte;
      stx = (b == StxV1) || (b == StxV2);
      if (it.command == CmdFlush) begin
        if (hold_valid) begin
          emit(hold_byte, 1'b1);
          close_junk();
        end
        return;
      end
      if (kind == KIND_V1 || kind == KIND_V2) begin
        pos = position;
        if (pos == 9'd1)
          target = 9'(b) + ((kind == KIND_V1) ? V1Overhead : V2Overhead);
        else if (pos == 9'd2 && kind == KIND_V2 && b[0])
          target = target + SignatureBytes;
        if (target != '0 && ({1'b0, pos} + 10'd1) >= {1'b0, target}) begin
          emit(b, 1'b1);
          kind     = KIND_NONE;
          position = '0;
          target   = '0;
        end else begin
          emit(b, 1'b0);
          position = pos + 9'd1;
        end
        return;
      end
      if (!packetise) begin
        if (hold_valid)
          emit(hold_byte, 1'b0);
        hold_valid = 1'b1;
        hold_byte  = b;
        kind       = KIND_JUNK;
        position   = '0;
        return;
      end
      if (kind == KIND_JUNK && hold_valid) begin
        if (stx) begin
          emit(hold_byte, 1'b1);
          hold_valid = 1'b0;
          hold_byte  = '0;
          open_packet(b);
        end else begin
          emit(hold_byte, 1'b0);
          junk_byte(b, {1'b0, position} + 10'd1);
        end
      end else if (stx) begin
        open_packet(b);
      end else begin
        junk_byte(b, 10'd1);
      end
    endfunction

    function void check_result(result_t r);
      result_t exp;
      if (due_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h segment_last %0b", r.out_byte, r.segment_last);
        failures++;
        return;
      end
      exp = due_bytes.pop_front();
      if (r.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", exp.out_byte, r.out_byte);
        failures++;
      end
      if (r.segment_last !== exp.segment_last) begin
        $error("segment_last: expected %0b, actual %0b", exp.segment_last, r.segment_last);
        failures++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  item_t                   item = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  result_t                 result;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  segment_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;
  int cycles = 0;

  mavlink_packet_segmenter_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(result);
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    item_t it;
    it.command   = CmdData;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_flush();
    item_t it;
    it.command   = CmdFlush;
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CfgAddrWidth'({RegPacketiseEnable, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic drain_and_set(input logic en);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, {31'd0, en}, rd);
    apb_xfer(1'b0, 32'd0, rd);
    if (rd[0] !== en) begin
      $error("packetise_enable: expected %0b, actual %0b", en, rd[0]);
      sb.failures++;
    end
    sb.packetise = en;
  endtask

  // One packet, well-formed or cut short, a junk run, a flush or a few bytes of noise.
  task automatic send_chunk();
    int         r;
    int         len;
    int         total;
    logic [7:0] stx;
    logic [7:0] flags;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      stx   = $urandom_range(0, 1) ? StxV1 : StxV2;
      len   = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
      flags = 8'($urandom_range(0, 255));
      total = len + ((stx == StxV1) ? int'(V1Overhead) : int'(V2Overhead));
      if (stx == StxV2 && flags[0])
        total += int'(SignatureBytes);
      if ($urandom_range(0, 19) == 0)
        total = $urandom_range(1, total - 1);
      for (int i = 0; i < total; i++) begin
        if (i == 0)
          b = stx;
        else if (i == 1)
          b = 8'(len);
        else if (i == 2 && stx == StxV2)
          b = flags;
        else
          b = 8'($urandom_range(0, 255));
        send_data(b);
      end
    end else if (r < 75) begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 253));
        if (b == StxV2)
          b = 8'hFF;
        send_data(b);
      end
    end else if (r < 85) begin
      send_flush();
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send_data(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 74;

    // Raw run with the reset setting, then a flush of the held byte and a flush with nothing held.
    send_data(8'h00);
    send_data(8'hFF);
    send_flush();
    send_flush();

    drain_and_set(1'b1);
    // Junk ended by a v1 start byte, with a flush in the middle of the packet.
    send_data(8'h11);
    send_data(StxV1);
    send_data(8'h00);
    send_data(8'hA5);
    send_data(8'h5A);
    send_flush();
    for (int i = 0; i < 4; i++)
      send_data(8'(8'h30 + i));
    // Junk ended by a v2 start byte, unsigned packet with empty payload.
    send_data(8'h33);
    send_data(StxV2);
    send_data(8'h00);
    send_data(8'h00);
    for (int i = 0; i < int'(V2Overhead) - 3; i++)
      send_data(8'(8'hC0 + i));

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_and_set(p % 2 == 0);
      sent = 0;
      while (sent < PhaseItems) send_chunk();
    end
    send_flush();
    drain();

    if (sb.failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
